// ===== sv/shfm_pkg.sv =====
// shfm_pkg: shared constants and types for the sensor health fault monitor
// action codes, fault codes, status flag bit positions, register indexes, reset values
// no dependencies
package shfm_pkg;

  localparam int WATCHED_TASKS = 4;

  // action codes
  localparam logic [1:0] ACT_REPORT = 2'd0;
  localparam logic [1:0] ACT_UPDATE = 2'd1;
  localparam logic [1:0] ACT_QUERY  = 2'd2;

  // fault codes, lower value wins
  localparam logic [3:0] FC_NONE        = 4'd0;
  localparam logic [3:0] FC_IMU_NC      = 4'd1;
  localparam logic [3:0] FC_BARO_NC     = 4'd2;
  localparam logic [3:0] FC_BARO_NODATA = 4'd3;
  localparam logic [3:0] FC_BARO_PRESS  = 4'd4;
  localparam logic [3:0] FC_BARO_CAL    = 4'd5;
  localparam logic [3:0] FC_SCHED       = 4'd6;
  localparam logic [3:0] FC_EST_DIVERGE = 4'd7;
  localparam logic [3:0] FC_RECORDER    = 4'd8;
  localparam logic [3:0] FC_IMU_STALE   = 4'd9;
  localparam logic [3:0] FC_EST_STALE   = 4'd10;
  localparam logic [3:0] FC_LIDAR_STALE = 4'd11;

  // status flag bit positions
  localparam int F_IMU_CONN    = 0;
  localparam int F_BARO_CONN   = 1;
  localparam int F_BARO_READY  = 2;
  localparam int F_BARO_VALID  = 3;
  localparam int F_BARO_CAL    = 4;
  localparam int F_BARO_HEALTH = 5;
  localparam int F_FLIGHT      = 6;
  localparam int F_VERT_USABLE = 7;
  localparam int F_EST_INHIBIT = 8;
  localparam int F_EST_HEALTHY = 9;
  localparam int F_SD_READY    = 10;
  localparam int F_SD_LOGGING  = 11;
  localparam int F_IMU_VALID   = 12;
  localparam int F_LIDAR_VALID = 13;

  localparam int FLAGS_W = 14;

  // register indexes
  localparam logic [2:0] CFG_IMU_LIMIT   = 3'd0;
  localparam logic [2:0] CFG_LIDAR_LIMIT = 3'd1;
  localparam logic [2:0] CFG_EST_LIMIT   = 3'd2;
  localparam logic [2:0] CFG_GRACE       = 3'd3;
  localparam logic [2:0] CFG_STALL       = 3'd4;
  localparam logic [2:0] CFG_LOG_EN      = 3'd5;

  localparam logic [31:0] RST_IMU_LIMIT   = 32'd20000;
  localparam logic [31:0] RST_LIDAR_LIMIT = 32'd200000;
  localparam logic [31:0] RST_EST_LIMIT   = 32'd50000;
  localparam logic [31:0] RST_GRACE       = 32'd3000;
  localparam logic [31:0] RST_STALL       = 32'd500;

  localparam logic [31:0] AGE_NONE = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [31:0] imu_limit_us;
    logic [31:0] lidar_limit_us;
    logic [31:0] est_limit_us;
    logic [31:0] grace_ms;
    logic [31:0] stall_ms;
    logic        log_en;
  } cfg_t;

  // evaluation results for the item in the input register
  typedef struct packed {
    logic [3:0] live_code;
    logic [3:0] new_code;
    logic       act;
    logic       healthy;
    logic [2:0] fresh;   // bit 0 imu, 1 lidar, 2 estimator
  } eval_t;

endpackage

// ===== sv/shfm_task_watch.sv =====
// shfm_task_watch: per-task run count and progress time table, scheduler liveness check
// uses shfm_pkg
module shfm_task_watch import shfm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        report,
  input  logic [1:0]  slot,
  input  logic [31:0] runs,
  input  logic [31:0] now_ms,
  input  logic [31:0] stall_ms,
  output logic        sched_ok
);

  logic [31:0] last_runs [WATCHED_TASKS];
  logic [31:0] progress_ms [WATCHED_TASKS];
  logic [WATCHED_TASKS-1:0] stalled;

  always_ff @(posedge clk) begin
    for (int i = 0; i < WATCHED_TASKS; i++) begin
      if (rst) begin
        last_runs[i]   <= '0;
        progress_ms[i] <= '0;
      end else if (report && (32'(slot) == 32'(i)) && (runs != last_runs[i])) begin
        last_runs[i]   <= runs;
        progress_ms[i] <= now_ms;
      end
    end
  end

  // wrapping elapsed time; a zero timeout marks every task stalled
  always_comb begin
    for (int i = 0; i < WATCHED_TASKS; i++) begin
      stalled[i] = 32'(now_ms - progress_ms[i]) >= stall_ms;
    end
  end

  assign sched_ok = ~|stalled;

endmodule

// ===== sv/shfm_fault_eval.sv =====
// shfm_fault_eval: sample ages, freshness, prioritized fault codes, health and actuator decision
// purely combinational; uses shfm_pkg
module shfm_fault_eval import shfm_pkg::*; (
  input  cfg_t               cfg,
  input  logic [31:0]        now_ms,
  input  logic [31:0]        now_us,
  input  logic [FLAGS_W-1:0] flags,
  input  logic [31:0]        imu_stamp_us,
  input  logic [31:0]        lidar_stamp_us,
  input  logic [31:0]        estimator_stamp_us,
  input  logic               sched_ok,
  input  logic               alive_flag,
  input  logic [3:0]         held_fault,
  output eval_t              ev
);

  logic [31:0] imu_age;
  logic [31:0] lidar_age;
  logic [31:0] est_age;
  logic        imu_fr;
  logic        lidar_fr;
  logic        est_fr;
  logic        past_grace;
  logic        flight;
  logic        rec_bad;
  logic        vert_ok;

  function automatic logic [3:0] fault_prio(
    input logic [FLAGS_W-1:0] f,
    input logic               grace_done,
    input logic               sched_bad,
    input logic               imu_ok,
    input logic               est_ok,
    input logic               lid_ok,
    input logic               recorder_bad
  );
    logic [3:0] c;
    logic       fl;
    fl = f[F_FLIGHT];
    if (!f[F_IMU_CONN])                               c = FC_IMU_NC;
    else if (!fl && !f[F_BARO_CONN])                  c = FC_BARO_NC;
    else if (!fl && !f[F_BARO_READY])                 c = FC_BARO_NODATA;
    else if (!fl && !f[F_BARO_VALID])                 c = FC_BARO_PRESS;
    else if (!fl && !f[F_BARO_CAL])                   c = FC_BARO_CAL;
    else if (sched_bad)                               c = FC_SCHED;
    else if (f[F_EST_INHIBIT])                        c = FC_EST_DIVERGE;
    else if (!fl && grace_done && recorder_bad)       c = FC_RECORDER;
    else if (grace_done && !imu_ok)                   c = FC_IMU_STALE;
    else if (grace_done && (!f[F_EST_HEALTHY] || !est_ok)) c = FC_EST_STALE;
    else if (grace_done && (fl ? !f[F_VERT_USABLE] : !lid_ok)) c = FC_LIDAR_STALE;
    else                                              c = FC_NONE;
    return c;
  endfunction

  always_comb begin
    // a zero stamp means no sample yet: largest age
    imu_age   = (imu_stamp_us == '0) ? AGE_NONE : 32'(now_us - imu_stamp_us);
    lidar_age = (lidar_stamp_us == '0) ? AGE_NONE : 32'(now_us - lidar_stamp_us);
    est_age   = (estimator_stamp_us == '0) ? AGE_NONE : 32'(now_us - estimator_stamp_us);

    imu_fr   = imu_age <= cfg.imu_limit_us;
    lidar_fr = lidar_age <= cfg.lidar_limit_us;
    est_fr   = est_age <= cfg.est_limit_us;

    past_grace = now_ms >= cfg.grace_ms;
    flight     = flags[F_FLIGHT];
    rec_bad    = cfg.log_en && (!flags[F_SD_READY] || !flags[F_SD_LOGGING]);

    ev.fresh = {est_fr, lidar_fr, imu_fr};

    ev.new_code = fault_prio(flags, past_grace, !sched_ok, imu_fr, est_fr, lidar_fr, rec_bad);

    // live path gates the scheduler fault by grace and also needs the sample valid bits
    ev.live_code = fault_prio(flags, past_grace, past_grace && !alive_flag,
                              flags[F_IMU_VALID] && imu_fr, est_fr,
                              flags[F_LIDAR_VALID] && lidar_fr, rec_bad);

    vert_ok = flight ? flags[F_VERT_USABLE] : (flags[F_BARO_HEALTH] && lidar_fr);

    ev.healthy = flags[F_IMU_CONN] && sched_ok && (ev.new_code == FC_NONE) &&
                 (!past_grace || (imu_fr && vert_ok && est_fr));

    // flight tolerates recorder faults, and baro/lidar faults while vertical aiding holds
    if (ev.live_code != FC_NONE) begin
      ev.act = 1'b1;
    end else if (flight && (held_fault == FC_RECORDER)) begin
      ev.act = 1'b0;
    end else if (flight && flags[F_VERT_USABLE] &&
                 ((held_fault inside {[FC_BARO_NC:FC_BARO_CAL]}) ||
                  (held_fault == FC_LIDAR_STALE))) begin
      ev.act = 1'b0;
    end else begin
      ev.act = held_fault != FC_NONE;
    end
  end

endmodule

// ===== sv/sensor_health_fault_monitor.sv =====
// sensor_health_fault_monitor: top level with input register, state, result register, config
// uses shfm_pkg, shfm_task_watch, shfm_fault_eval

// Takes one beat per clock unless stalled and returns exactly one result beat for each. A
// beat accepted at a clock edge lands in the input register, is evaluated by the age compares,
// the four-task stall check and the fault priority chain, and is captured in the result
// register once that register is empty or being drained. Throughput is one beat per cycle,
// as each beat needs a single pass through that compare and priority logic; in_ready drops
// only during reset and while both registers are full and out_ready is low. The task table
// lives in flip-flops cleared by reset, so the block is ready right after reset.
// Register writes on the cfg channel are taken in any cycle outside reset and should be done
// while no beat is in flight.
module sensor_health_fault_monitor import shfm_pkg::*; (
  input  logic               clk,
  input  logic               rst,

  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         action,
  input  logic [31:0]        now_ms,
  input  logic [31:0]        now_us,
  input  logic [1:0]         task_slot,
  input  logic [31:0]        task_runs,
  input  logic [FLAGS_W-1:0] status_flags,
  input  logic [31:0]        imu_stamp_us,
  input  logic [31:0]        lidar_stamp_us,
  input  logic [31:0]        estimator_stamp_us,

  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         fault_id,
  output logic               actuator_fault,
  output logic               sys_healthy,
  output logic               scheduler_alive,
  output logic               imu_current,
  output logic               lidar_current,
  output logic               estimator_fresh,
  output logic [31:0]        update_count,

  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  cfg_t cfg;

  // input register
  logic               s1_valid;
  logic [1:0]         s1_action;
  logic [31:0]        s1_now_ms;
  logic [31:0]        s1_now_us;
  logic [1:0]         s1_slot;
  logic [31:0]        s1_runs;
  logic [FLAGS_W-1:0] s1_flags;
  logic [31:0]        s1_imu_stamp;
  logic [31:0]        s1_lidar_stamp;
  logic [31:0]        s1_est_stamp;

  // monitor state
  logic        alive_flag;
  logic [3:0]  held_fault;
  logic [2:0]  fresh_flags;
  logic        healthy_flag;
  logic [31:0] updates_done;

  logic        alive_flag_next;
  logic [3:0]  held_fault_next;
  logic [2:0]  fresh_flags_next;
  logic        healthy_flag_next;
  logic [31:0] updates_done_next;

  logic        advance;
  logic        is_update;
  logic        is_query;
  logic        sched_ok;
  eval_t       ev;

  assign advance   = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !rst && (!s1_valid || advance);
  assign cfg_ready = !rst;
  assign is_update = s1_action == ACT_UPDATE;
  assign is_query  = s1_action == ACT_QUERY;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.imu_limit_us   <= RST_IMU_LIMIT;
      cfg.lidar_limit_us <= RST_LIDAR_LIMIT;
      cfg.est_limit_us   <= RST_EST_LIMIT;
      cfg.grace_ms       <= RST_GRACE;
      cfg.stall_ms       <= RST_STALL;
      cfg.log_en         <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IMU_LIMIT:   cfg.imu_limit_us   <= cfg_data;
        CFG_LIDAR_LIMIT: cfg.lidar_limit_us <= cfg_data;
        CFG_EST_LIMIT:   cfg.est_limit_us   <= cfg_data;
        CFG_GRACE:       cfg.grace_ms       <= cfg_data;
        CFG_STALL:       cfg.stall_ms       <= cfg_data;
        CFG_LOG_EN:      cfg.log_en         <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_action      <= action;
      s1_now_ms      <= now_ms;
      s1_now_us      <= now_us;
      s1_slot        <= task_slot;
      s1_runs        <= task_runs;
      s1_flags       <= status_flags;
      s1_imu_stamp   <= imu_stamp_us;
      s1_lidar_stamp <= lidar_stamp_us;
      s1_est_stamp   <= estimator_stamp_us;
    end
  end

  shfm_task_watch u_task_watch (
    .clk      (clk),
    .rst      (rst),
    .report   (advance && (s1_action == ACT_REPORT)),
    .slot     (s1_slot),
    .runs     (s1_runs),
    .now_ms   (s1_now_ms),
    .stall_ms (cfg.stall_ms),
    .sched_ok (sched_ok)
  );

  shfm_fault_eval u_fault_eval (
    .cfg                (cfg),
    .now_ms             (s1_now_ms),
    .now_us             (s1_now_us),
    .flags              (s1_flags),
    .imu_stamp_us       (s1_imu_stamp),
    .lidar_stamp_us     (s1_lidar_stamp),
    .estimator_stamp_us (s1_est_stamp),
    .sched_ok           (sched_ok),
    .alive_flag         (alive_flag),
    .held_fault         (held_fault),
    .ev                 (ev)
  );

  always_comb begin
    alive_flag_next   = is_update ? sched_ok : alive_flag;
    held_fault_next   = is_update ? ev.new_code : held_fault;
    fresh_flags_next  = is_update ? ev.fresh : fresh_flags;
    healthy_flag_next = is_update ? ev.healthy : healthy_flag;
    updates_done_next = is_update ? 32'(updates_done + 32'd1) : updates_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alive_flag   <= 1'b0;
      held_fault   <= FC_NONE;
      fresh_flags  <= '0;
      healthy_flag <= 1'b0;
      updates_done <= '0;
    end else if (advance) begin
      alive_flag   <= alive_flag_next;
      held_fault   <= held_fault_next;
      fresh_flags  <= fresh_flags_next;
      healthy_flag <= healthy_flag_next;
      updates_done <= updates_done_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      fault_id        <= is_query ? ev.live_code : held_fault_next;
      actuator_fault  <= is_query && ev.act;
      sys_healthy     <= healthy_flag_next;
      scheduler_alive <= alive_flag_next;
      imu_current     <= fresh_flags_next[0];
      lidar_current   <= fresh_flags_next[1];
      estimator_fresh <= fresh_flags_next[2];
      update_count    <= updates_done_next;
    end
  end

`ifndef SYNTHESIS
  a_update_counts: assert property (@(posedge clk) disable iff (rst)
    (advance && is_update) |=> (updates_done == 32'($past(updates_done) + 32'd1)))
    else $error("update counter did not step on a periodic update");

  a_state_held: assert property (@(posedge clk) disable iff (rst)
    !(advance && is_update) |=> ($stable(held_fault) && $stable(updates_done)))
    else $error("monitor state changed without a periodic update");

  a_code_range: assert property (@(posedge clk) disable iff (rst)
    held_fault <= FC_LIDAR_STALE)
    else $error("latched fault code out of range");

  a_healthy_clean: assert property (@(posedge clk) disable iff (rst)
    healthy_flag |-> (held_fault == FC_NONE) && alive_flag)
    else $error("healthy while a fault is latched or scheduler stalled");

  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (s1_valid && out_valid && !out_ready))
    else $error("input stalled with room in the pipeline");
`endif

endmodule

// ===== test/sensor_health_fault_monitor_tb.sv =====
// sensor_health_fault_monitor_tb: self-checking bench for the sensor health fault monitor
// drives task reports, periodic updates and fault queries, predicts every result beat
// depends on shfm_pkg and sensor_health_fault_monitor
module sensor_health_fault_monitor_tb;
  import shfm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] ACT_SPARE = 2'd3;  // unused action code, block only reports state
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [1:0]         action;
    logic [31:0]        now_ms;
    logic [31:0]        now_us;
    logic [1:0]         slot;
    logic [31:0]        runs;
    logic [FLAGS_W-1:0] flags;
    logic [31:0]        imu_st;
    logic [31:0]        lid_st;
    logic [31:0]        est_st;
  } sample_t;

  typedef struct packed {
    logic [3:0]  code;
    logic        act;
    logic        ok;
    logic        alive;
    logic        imu_fr;
    logic        lid_fr;
    logic        est_fr;
    logic [31:0] count;
  } health_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         action = '0;
  logic [31:0]        now_ms = '0;
  logic [31:0]        now_us = '0;
  logic [1:0]         task_slot = '0;
  logic [31:0]        task_runs = '0;
  logic [FLAGS_W-1:0] status_flags = '0;
  logic [31:0]        imu_stamp_us = '0;
  logic [31:0]        lidar_stamp_us = '0;
  logic [31:0]        estimator_stamp_us = '0;

  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [3:0]         fault_id;
  logic               actuator_fault;
  logic               sys_healthy;
  logic               scheduler_alive;
  logic               imu_current;
  logic               lidar_current;
  logic               estimator_fresh;
  logic [31:0]        update_count;

  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;

  sensor_health_fault_monitor u_top (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .action             (action),
    .now_ms             (now_ms),
    .now_us             (now_us),
    .task_slot          (task_slot),
    .task_runs          (task_runs),
    .status_flags       (status_flags),
    .imu_stamp_us       (imu_stamp_us),
    .lidar_stamp_us     (lidar_stamp_us),
    .estimator_stamp_us (estimator_stamp_us),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .fault_id           (fault_id),
    .actuator_fault     (actuator_fault),
    .sys_healthy        (sys_healthy),
    .scheduler_alive    (scheduler_alive),
    .imu_current        (imu_current),
    .lidar_current      (lidar_current),
    .estimator_fresh    (estimator_fresh),
    .update_count       (update_count),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state and register copy
  cfg_t        m_cfg;
  logic [31:0] m_runs [WATCHED_TASKS];
  logic [31:0] m_prog [WATCHED_TASKS];
  logic        m_alive;
  logic [3:0]  m_latched;
  logic [2:0]  m_fresh;
  logic        m_ok;
  logic [31:0] m_updates;

  health_t due_results [$];
  int      mismatches = 0;
  int      cycle_count = 0;
  bit      idle_on = 1'b1;
  int      hold_req = 0;

  // stimulus time base and per-task run counters
  logic [31:0] clock_ms;
  logic [31:0] clock_us;
  logic [31:0] run_ctr [WATCHED_TASKS];

  function automatic logic [31:0] sample_age(logic [31:0] now, logic [31:0] stamp);
    return (stamp == 32'd0) ? AGE_NONE : now - stamp;
  endfunction

  function automatic logic [3:0] rank_fault(logic [FLAGS_W-1:0] f, logic past_grace,
                                            logic sched_bad, logic imu_bad,
                                            logic est_bad, logic lid_bad);
    logic flight;
    flight = f[F_FLIGHT];
    if (!f[F_IMU_CONN]) return FC_IMU_NC;
    if (!flight) begin
      if (!f[F_BARO_CONN]) return FC_BARO_NC;
      if (!f[F_BARO_READY]) return FC_BARO_NODATA;
      if (!f[F_BARO_VALID]) return FC_BARO_PRESS;
      if (!f[F_BARO_CAL]) return FC_BARO_CAL;
    end
    if (sched_bad) return FC_SCHED;
    if (f[F_EST_INHIBIT]) return FC_EST_DIVERGE;
    if (!flight && past_grace && m_cfg.log_en && (!f[F_SD_READY] || !f[F_SD_LOGGING]))
      return FC_RECORDER;
    if (past_grace) begin
      if (imu_bad) return FC_IMU_STALE;
      if (!f[F_EST_HEALTHY] || est_bad) return FC_EST_STALE;
      if (flight ? !f[F_VERT_USABLE] : lid_bad) return FC_LIDAR_STALE;
    end
    return FC_NONE;
  endfunction

  function automatic logic actuator_block(logic [3:0] live, logic [FLAGS_W-1:0] f);
    if (live != FC_NONE) return 1'b1;
    if (f[F_FLIGHT]) begin
      if (m_latched == FC_RECORDER) return 1'b0;
      // baro or lidar trouble is tolerated in flight while vertical aiding holds
      if (((m_latched >= FC_BARO_NC && m_latched <= FC_BARO_CAL) ||
           m_latched == FC_LIDAR_STALE) && f[F_VERT_USABLE]) return 1'b0;
    end
    return m_latched != FC_NONE;
  endfunction

  function automatic health_t health_step(sample_t s);
    health_t     r;
    logic [3:0]  code;
    logic        past, sched_ok, ifr, lfr, efr, vert_ok;
    int          i;
    past = s.now_ms >= m_cfg.grace_ms;
    ifr = sample_age(s.now_us, s.imu_st) <= m_cfg.imu_limit_us;
    lfr = sample_age(s.now_us, s.lid_st) <= m_cfg.lidar_limit_us;
    efr = sample_age(s.now_us, s.est_st) <= m_cfg.est_limit_us;
    code = m_latched;
    r.act = 1'b0;
    case (s.action)
      ACT_REPORT: begin
        if (s.runs != m_runs[s.slot]) begin
          m_runs[s.slot] = s.runs;
          m_prog[s.slot] = s.now_ms;
        end
      end
      ACT_UPDATE: begin
        sched_ok = 1'b1;
        for (i = 0; i < WATCHED_TASKS; i++) begin
          if (s.now_ms - m_prog[i] >= m_cfg.stall_ms) sched_ok = 1'b0;
        end
        code = rank_fault(s.flags, past, !sched_ok, !ifr, !efr, !lfr);
        vert_ok = s.flags[F_FLIGHT] ? s.flags[F_VERT_USABLE]
                                    : (s.flags[F_BARO_HEALTH] && lfr);
        m_ok = s.flags[F_IMU_CONN] && sched_ok && code == FC_NONE &&
               (!past || (ifr && vert_ok && efr));
        m_alive = sched_ok;
        m_latched = code;
        m_fresh = {efr, lfr, ifr};
        m_updates = m_updates + 32'd1;
      end
      ACT_QUERY: begin
        // live code: scheduler only counts after grace, validity bits gate freshness
        code = rank_fault(s.flags, past, past && !m_alive,
                          !s.flags[F_IMU_VALID] || !ifr, !efr,
                          !s.flags[F_LIDAR_VALID] || !lfr);
        r.act = actuator_block(code, s.flags);
      end
      default: begin
      end
    endcase
    r.code = code;
    r.ok = m_ok;
    r.alive = m_alive;
    r.imu_fr = m_fresh[0];
    r.lid_fr = m_fresh[1];
    r.est_fr = m_fresh[2];
    r.count = m_updates;
    return r;
  endfunction

  function automatic cfg_t make_cfg(logic [31:0] imu, logic [31:0] lid, logic [31:0] est,
                                    logic [31:0] grace, logic [31:0] stall, logic log_en);
    cfg_t c;
    c.imu_limit_us = imu;
    c.lidar_limit_us = lid;
    c.est_limit_us = est;
    c.grace_ms = grace;
    c.stall_ms = stall;
    c.log_en = log_en;
    return c;
  endfunction

  function automatic logic [FLAGS_W-1:0] sound_flags(logic flight);
    logic [FLAGS_W-1:0] f;
    f = '1;
    f[F_EST_INHIBIT] = 1'b0;
    f[F_FLIGHT] = flight;
    return f;
  endfunction

  function automatic logic [FLAGS_W-1:0] without(logic [FLAGS_W-1:0] f, int b);
    f[b] = 1'b0;
    return f;
  endfunction

  function automatic sample_t make_sample(logic [1:0] act, logic [31:0] ms, logic [31:0] us,
                                          logic [1:0] slot, logic [31:0] runs,
                                          logic [FLAGS_W-1:0] flags, logic [31:0] imu,
                                          logic [31:0] lid, logic [31:0] est);
    sample_t s;
    s.action = act;
    s.now_ms = ms;
    s.now_us = us;
    s.slot = slot;
    s.runs = runs;
    s.flags = flags;
    s.imu_st = imu;
    s.lid_st = lid;
    s.est_st = est;
    return s;
  endfunction

  // mostly near the freshness limit, with exact boundary ages, no-sample and junk stamps
  function automatic logic [31:0] draw_stamp(logic [31:0] lim);
    logic [31:0] span;
    int          p;
    p = $urandom_range(0, 19);
    span = (lim >= 32'hCCCC_CCCC) ? 32'hFFFF_FFFF : lim + (lim >> 2) + 32'd2;
    case (p)
      0: return 32'd0;
      1: return $urandom;
      2: return clock_us - lim;
      3: return clock_us - lim - 32'd1;
      default: return clock_us - $urandom_range(0, span);
    endcase
  endfunction

  function automatic sample_t draw_sample();
    sample_t s;
    int      pick;
    int      k;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      s.action = 2'($urandom_range(0, 3));
      s.now_ms = $urandom;
      s.now_us = $urandom;
      s.slot = 2'($urandom_range(0, 3));
      s.runs = $urandom;
      s.flags = FLAGS_W'($urandom);
      s.imu_st = $urandom;
      s.lid_st = $urandom;
      s.est_st = $urandom;
      return s;
    end
    clock_ms = clock_ms + $urandom_range(0, 40);
    clock_us = clock_us + $urandom_range(0, 40000);
    pick = $urandom_range(0, 99);
    s.action = (pick < 45) ? ACT_REPORT : (pick < 75) ? ACT_UPDATE :
               (pick < 97) ? ACT_QUERY : ACT_SPARE;
    s.now_ms = clock_ms;
    s.now_us = clock_us;
    s.slot = 2'($urandom_range(0, 3));
    if (s.action == ACT_REPORT && $urandom_range(0, 3) != 0)
      run_ctr[s.slot] = run_ctr[s.slot] + 32'd1;
    s.runs = run_ctr[s.slot];
    s.flags = sound_flags(1'($urandom_range(0, 1)));
    if ($urandom_range(0, 9) < 4) begin
      k = $urandom_range(0, FLAGS_W - 1);
      s.flags[k] = ~s.flags[k];
    end
    s.imu_st = draw_stamp(m_cfg.imu_limit_us);
    s.lid_st = draw_stamp(m_cfg.lidar_limit_us);
    s.est_st = draw_stamp(m_cfg.est_limit_us);
    return s;
  endfunction

  task automatic send_item(sample_t s);
    int gap;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= s.action;
    now_ms <= s.now_ms;
    now_us <= s.now_us;
    task_slot <= s.slot;
    task_runs <= s.runs;
    status_flags <= s.flags;
    imu_stamp_us <= s.imu_st;
    lidar_stamp_us <= s.lid_st;
    estimator_stamp_us <= s.est_st;
    do @(posedge clk); while (!in_ready);
    due_results.push_back(health_step(s));
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_IMU_LIMIT:   m_cfg.imu_limit_us = data;
      CFG_LIDAR_LIMIT: m_cfg.lidar_limit_us = data;
      CFG_EST_LIMIT:   m_cfg.est_limit_us = data;
      CFG_GRACE:       m_cfg.grace_ms = data;
      CFG_STALL:       m_cfg.stall_ms = data;
      CFG_LOG_EN:      m_cfg.log_en = data[0];
      default: begin
      end
    endcase
  endtask

  task automatic load_config(cfg_t c);
    write_reg(CFG_IMU_LIMIT, c.imu_limit_us);
    write_reg(CFG_LIDAR_LIMIT, c.lidar_limit_us);
    write_reg(CFG_EST_LIMIT, c.est_limit_us);
    write_reg(CFG_GRACE, c.grace_ms);
    write_reg(CFG_STALL, c.stall_ms);
    write_reg(CFG_LOG_EN, {31'd0, c.log_en});
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(int n);
    int i;
    for (i = 0; i < n; i++) begin
      if (i > 0 && i % 50 == 0) idle_on = ($urandom_range(0, 3) != 0);
      send_item(draw_sample());
    end
  endtask

  task automatic start_clock(logic [31:0] ms);
    clock_ms = ms;
    clock_us = $urandom;
  endtask

  task automatic test_directed();
    logic [31:0]        u;
    logic [31:0]        ok_st;
    logic [FLAGS_W-1:0] g;
    logic [FLAGS_W-1:0] a;
    int                 i;
    u = 32'd1_000_000;
    ok_st = u - 32'd1000;
    g = sound_flags(1'b0);
    a = sound_flags(1'b1);
    send_item(make_sample(ACT_UPDATE, 0, u, 2'd0, 0, '0, 0, 0, 0));
    send_item(make_sample(ACT_QUERY, 0, u, 2'd0, 0, '0, 0, 0, 0));
    send_item(make_sample(ACT_QUERY, '1, '1, 2'd3, '1, '1, '1, '1, '1));
    for (i = 0; i < WATCHED_TASKS; i++)
      send_item(make_sample(ACT_REPORT, 100, u, 2'(i), (i == 3) ? 32'hFFFF_FFFF : i + 1, g,
                            ok_st, ok_st, ok_st));
    send_item(make_sample(ACT_SPARE, 400, $urandom, 2'd2, $urandom, FLAGS_W'($urandom),
                          $urandom, $urandom, $urandom));
    send_item(make_sample(ACT_UPDATE, 300, u, 2'd0, 0, g, ok_st, ok_st, ok_st));
    send_item(make_sample(ACT_QUERY, 300, u, 2'd0, 0, without(g, F_BARO_CONN),
                          ok_st, ok_st, ok_st));
    send_item(make_sample(ACT_QUERY, 300, u, 2'd0, 0, without(g, F_BARO_READY),
                          ok_st, ok_st, ok_st));
    send_item(make_sample(ACT_QUERY, 300, u, 2'd0, 0, without(g, F_BARO_VALID),
                          ok_st, ok_st, ok_st));
    send_item(make_sample(ACT_QUERY, 300, u, 2'd0, 0, without(g, F_BARO_CAL),
                          ok_st, ok_st, ok_st));
    send_item(make_sample(ACT_QUERY, 300, u, 2'd0, 0, without(a, F_BARO_CONN),
                          ok_st, ok_st, ok_st));
    // tasks last moved at 100 ms, so this update sees a stall
    send_item(make_sample(ACT_UPDATE, 5000, u, 2'd0, 0, g, ok_st, ok_st, ok_st));
    send_item(make_sample(ACT_QUERY, 5000, u, 2'd0, 0, g, ok_st, ok_st, ok_st));
    for (i = 0; i < WATCHED_TASKS; i++)
      send_item(make_sample(ACT_REPORT, 5000, u, 2'(i), i + 10, g, ok_st, ok_st, ok_st));
    send_item(make_sample(ACT_UPDATE, 5100, u, 2'd0, 0, without(g, F_SD_LOGGING),
                          ok_st, ok_st, ok_st));
    send_item(make_sample(ACT_UPDATE, 5100, u, 2'd0, 0, g, 0, ok_st, ok_st));
    send_item(make_sample(ACT_UPDATE, 5100, u, 2'd0, 0, without(g, F_EST_HEALTHY),
                          ok_st, ok_st, ok_st));
    send_item(make_sample(ACT_UPDATE, 5100, u, 2'd0, 0, g, ok_st, u - 32'd500000, ok_st));
    send_item(make_sample(ACT_UPDATE, 5100, u, 2'd0, 0, without(a, F_VERT_USABLE),
                          ok_st, ok_st, ok_st));
    send_item(make_sample(ACT_QUERY, 5100, u, 2'd0, 0, a, ok_st, ok_st, ok_st));
    // stamp ahead of now_us wraps to a huge age
    send_item(make_sample(ACT_QUERY, 5100, u, 2'd0, 0, g, u + 32'd5, ok_st, ok_st));
    wait_drain();
  endtask

  task automatic test_defaults();
    start_clock(0);
    run_random(330);
    wait_drain();
  endtask

  task automatic test_low_limits();
    load_config(make_cfg(0, 0, 0, 0, 1, 1'b0));
    start_clock($urandom_range(0, 100000));
    run_random(250);
    wait_drain();
  endtask

  task automatic test_high_limits();
    load_config(make_cfg('1, '1, '1, '1, '1, 1'b1));
    start_clock(32'hFFFF_FF00);
    run_random(250);
    wait_drain();
  endtask

  task automatic test_zero_stall();
    load_config(make_cfg(RST_IMU_LIMIT, RST_LIDAR_LIMIT, RST_EST_LIMIT, 0, 0, 1'b1));
    start_clock($urandom);
    run_random(100);
    wait_drain();
  endtask

  task automatic test_wrapped_time();
    int n;
    for (n = 0; n < 2; n++) begin
      load_config(make_cfg($urandom_range(1000, 40000), $urandom_range(10000, 400000),
                           $urandom_range(5000, 100000), $urandom_range(0, 5000),
                           $urandom_range(1, 1000), 1'($urandom_range(0, 1))));
      start_clock(32'hFFFF_F000 - $urandom_range(0, 2000));
      run_random(200);
      wait_drain();
    end
  endtask

  task automatic test_backpressure();
    int i;
    load_config(make_cfg(RST_IMU_LIMIT, RST_LIDAR_LIMIT, RST_EST_LIMIT, RST_GRACE,
                         RST_STALL, 1'b1));
    start_clock(0);
    idle_on = 1'b0;
    hold_req = 120;
    for (i = 0; i < 40; i++) send_item(draw_sample());
    wait_drain();
    idle_on = 1'b1;
    run_random(110);
    wait_drain();
  endtask

  // result side: random hold-off per beat, or a long hold when one is requested
  initial begin : result_ready
    int gap;
    forever begin
      if (hold_req > 0) begin
        gap = hold_req;
        hold_req = 0;
      end else begin
        gap = idle_on ? $urandom_range(0, 7) : 0;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && !rst));
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : result_check
    health_t want;
    if (!rst && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result beat, fault_id %0d", $time, fault_id);
        mismatches++;
      end else begin
        want = due_results.pop_front();
        check_field("fault_id", 32'(want.code), 32'(fault_id));
        check_field("actuator_fault", 32'(want.act), 32'(actuator_fault));
        check_field("sys_healthy", 32'(want.ok), 32'(sys_healthy));
        check_field("scheduler_alive", 32'(want.alive), 32'(scheduler_alive));
        check_field("imu_current", 32'(want.imu_fr), 32'(imu_current));
        check_field("lidar_current", 32'(want.lid_fr), 32'(lidar_current));
        check_field("estimator_fresh", 32'(want.est_fr), 32'(estimator_fresh));
        check_field("update_count", want.count, update_count);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, due_results.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin : main
    int i;
    m_cfg = make_cfg(RST_IMU_LIMIT, RST_LIDAR_LIMIT, RST_EST_LIMIT, RST_GRACE,
                     RST_STALL, 1'b1);
    for (i = 0; i < WATCHED_TASKS; i++) begin
      m_runs[i] = '0;
      m_prog[i] = '0;
      run_ctr[i] = '0;
    end
    m_alive = 1'b0;
    m_latched = FC_NONE;
    m_fresh = '0;
    m_ok = 1'b0;
    m_updates = '0;
    clock_ms = '0;
    clock_us = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_defaults();
    test_low_limits();
    test_high_limits();
    test_zero_stall();
    test_wrapped_time();
    test_backpressure();
    wait_drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sensor_health_fault_monitor.f =====
sv/shfm_pkg.sv
sv/shfm_task_watch.sv
sv/shfm_fault_eval.sv
sv/sensor_health_fault_monitor.sv
test/sensor_health_fault_monitor_tb.sv
